/* rtl/fl1ag_pkg.sv */
// Shared constants and types for the L1/adaptive-rate optimizer update core.
package fl1ag_pkg;

   localparam int NUM_FEATURES = 65536;
   localparam int ADDR_W       = $clog2(NUM_FEATURES);
   localparam int IDX_W        = 16;
   localparam int WORD_W       = 32;
   localparam int ACC_W        = 48;
   localparam int SQRT_STAGES  = 32;
   localparam int DIV_STAGES   = 32;
   localparam int CSR_IDX_W    = 8;

   localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_LEARNING_RATE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_L1_STRENGTH   = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_L1_ENABLE     = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ADAPTIVE_MODE = 8'd3;

   localparam logic [WORD_W-1:0] LR_RESET = 32'd66;

   // per-item sideband that rides along the pipeline
   typedef struct packed {
      logic [IDX_W-1:0]  idx;
      logic [WORD_W-1:0] weight;
      logic [WORD_W-1:0] gmag;
      logic              gneg;
      logic              pass;
      logic              aflag;
   } meta_type;

endpackage

/* rtl/fobos_l1_adagrad_update_core.sv */
// Optimizer update core: one coordinate per transfer, one result per item, in order. Items are
// accepted every cycle unless the pipeline stalls or the store is being cleared, and a result
// reaches rsp_tvalid through one accept stage, the square root (32 stages), the rate divider
// (32 stages), the step product, the step add and the output register. The pipeline stalls
// only while the output register holds an untaken result and the last stage is full. The
// squared-gradient store is read at acceptance and written back from the accept stage
// register, with the last write forwarded, so repeated indexes follow back to back. After
// reset the store is zeroed by a clearing pass over all NUM_FEATURES (65536) entries during
// which req_tready stays low; configuration writes are taken at all times.
module fobos_l1_adagrad_update_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [79:0]                       req_tdata,  // feature_index, weight_in, gradient
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [47:0]                       rsp_tdata,  // result_index, weight_out
   output logic                              rsp_tuser,  // overflow_flag
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fl1ag_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                       csr_data
);

   localparam int AW = fl1ag_pkg::ADDR_W;

   // configuration
   logic [31:0] lr_ff, l1_str_ff;
   logic        l1_en_ff, adapt_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff     <= fl1ag_pkg::LR_RESET;
         l1_str_ff <= '0;
         l1_en_ff  <= 1'b0;
         adapt_ff  <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            fl1ag_pkg::CSR_LEARNING_RATE: lr_ff     <= csr_data;
            fl1ag_pkg::CSR_L1_STRENGTH:   l1_str_ff <= csr_data;
            fl1ag_pkg::CSR_L1_ENABLE:     l1_en_ff  <= csr_data[0];
            fl1ag_pkg::CSR_ADAPTIVE_MODE: adapt_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // clearing pass
   logic [AW:0] clr_cnt_ff;
   logic        clearing;

   assign clearing = (clr_cnt_ff < (AW+1)'(fl1ag_pkg::NUM_FEATURES));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (clearing) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   // pipeline advance: only a full tail facing a blocked output stalls
   logic sa_valid_ff;
   logic rsp_valid_ff;
   logic adv;
   logic req_xfer;

   assign adv        = !(rsp_valid_ff && !rsp_tready && sa_valid_ff);
   assign req_tready = !clearing && adv;
   assign req_xfer   = req_tvalid && req_tready;

   // accept stage
   logic [15:0]         in_idx;
   logic [31:0]         in_w, in_g, in_gmag;
   logic [63:0]         in_sqprod;
   fl1ag_pkg::meta_type in_meta;

   always_comb begin
      in_idx        = req_tdata[15:0];
      in_w          = req_tdata[47:16];
      in_g          = req_tdata[79:48];
      in_gmag       = in_g[31] ? (~in_g + 32'd1) : in_g;
      in_sqprod     = in_gmag * in_gmag;
      in_meta.idx   = in_idx;
      in_meta.weight = in_w;
      in_meta.gmag  = in_gmag;
      in_meta.gneg  = in_g[31];
      in_meta.pass  = (in_idx == 16'd0) || (32'(in_idx) >= fl1ag_pkg::NUM_FEATURES);
      in_meta.aflag = 1'b0;
   end

   logic                s1_valid_ff;
   fl1ag_pkg::meta_type s1_meta_ff;
   logic [47:0]         s1_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_xfer;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_meta_ff <= in_meta;
         s1_sq_ff   <= in_sqprod[63:16];
      end
   end

   // accumulator read-modify-write
   logic [47:0]   ram_rdata;
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [47:0]   ram_wr_data;
   logic          wr_valid_ff;
   logic [AW-1:0] wr_addr_ff;
   logic [47:0]   wr_data_ff;
   logic [AW-1:0] s1_addr;
   logic [47:0]   acc_old, acc_new;
   logic [48:0]   acc_sum;
   logic          acc_upd;
   fl1ag_pkg::meta_type s1_meta_out;

   always_comb begin
      s1_addr  = AW'(s1_meta_ff.idx);
      acc_old  = (wr_valid_ff && (wr_addr_ff == s1_addr)) ? wr_data_ff : ram_rdata;
      acc_sum  = {1'b0, acc_old} + {1'b0, s1_sq_ff};
      acc_new  = acc_sum[48] ? fl1ag_pkg::ACC_MAX : acc_sum[47:0];
      acc_upd  = s1_valid_ff && !s1_meta_ff.pass && adapt_ff && (s1_meta_ff.gmag != 32'd0);
      s1_meta_out       = s1_meta_ff;
      s1_meta_out.aflag = acc_upd && acc_sum[48];
      if (clearing) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_cnt_ff[AW-1:0];
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = acc_upd && adv;
         ram_wr_addr = s1_addr;
         ram_wr_data = acc_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_valid_ff <= 1'b0;
      end else if (!clearing && acc_upd && adv) begin
         wr_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!clearing && acc_upd && adv) begin
         wr_addr_ff <= s1_addr;
         wr_data_ff <= acc_new;
      end
   end

   fl1ag_ram #(
      .WIDTH (fl1ag_pkg::ACC_W),
      .DEPTH (fl1ag_pkg::NUM_FEATURES)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_xfer),
      .rd_addr (AW'(in_idx)),
      .rd_data (ram_rdata)
   );

   // rate pipeline
   logic                rt_valid;
   fl1ag_pkg::meta_type rt_meta;
   logic [31:0]         rt_quot;

   fl1ag_rate u_rate (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s1_valid_ff),
      .in_meta   (s1_meta_out),
      .in_acc    (acc_old),
      .lr        (lr_ff),
      .out_valid (rt_valid),
      .out_meta  (rt_meta),
      .out_quot  (rt_quot)
   );

   // step and threshold products
   logic [31:0] rate;
   logic [63:0] step_prod, thr_prod;

   always_comb begin
      rate      = adapt_ff ? rt_quot : lr_ff;
      step_prod = rate * rt_meta.gmag;
      thr_prod  = l1_str_ff * rate;
   end

   logic                sm_valid_ff;
   fl1ag_pkg::meta_type sm_meta_ff;
   logic [47:0]         sm_step_ff, sm_thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sm_valid_ff <= 1'b0;
      end else if (adv) begin
         sm_valid_ff <= rt_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sm_meta_ff <= rt_meta;
         sm_step_ff <= step_prod[63:16];
         sm_thr_ff  <= thr_prod[63:16];
      end
   end

   // gradient step
   logic signed [49:0] w_ext, w_step, step_ext;

   always_comb begin
      w_ext    = {{18{sm_meta_ff.weight[31]}}, sm_meta_ff.weight};
      step_ext = {2'b00, sm_step_ff};
      w_step   = sm_meta_ff.gneg ? (w_ext + step_ext) : (w_ext - step_ext);
   end

   fl1ag_pkg::meta_type sa_meta_ff;
   logic signed [49:0]  sa_w_ff;
   logic [47:0]         sa_thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_valid_ff <= 1'b0;
      end else if (adv) begin
         sa_valid_ff <= sm_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sa_meta_ff <= sm_meta_ff;
         sa_w_ff    <= w_step;
         sa_thr_ff  <= sm_thr_ff;
      end
   end

   // soft threshold, then clamp to 32 bits
   localparam logic signed [49:0] W_MAX = 50'sd2147483647;
   localparam logic signed [49:0] W_MIN = -50'sd2147483648;

   logic signed [49:0] thr_ext, w_l1, w_diff;
   logic [31:0]        w_final;
   logic               sat;

   always_comb begin
      thr_ext = {2'b00, sa_thr_ff};
      w_diff  = sa_w_ff[49] ? (sa_w_ff + thr_ext) : (sa_w_ff - thr_ext);
      w_l1    = sa_w_ff;
      if (l1_en_ff && (sa_w_ff != 50'sd0)) begin
         if (!sa_w_ff[49]) begin
            w_l1 = (w_diff > 50'sd0) ? w_diff : 50'sd0;
         end else begin
            w_l1 = (w_diff < 50'sd0) ? w_diff : 50'sd0;
         end
      end
      sat = 1'b0;
      if (w_l1 > W_MAX) begin
         w_final = W_MAX[31:0];
         sat     = 1'b1;
      end else if (w_l1 < W_MIN) begin
         w_final = W_MIN[31:0];
         sat     = 1'b1;
      end else begin
         w_final = w_l1[31:0];
      end
   end

   // output register
   logic [15:0] rsp_idx_ff;
   logic [31:0] rsp_w_ff;
   logic        rsp_flag_ff;
   logic        out_load;

   assign out_load = sa_valid_ff && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_idx_ff  <= sa_meta_ff.idx;
         rsp_w_ff    <= sa_meta_ff.pass ? sa_meta_ff.weight : w_final;
         rsp_flag_ff <= sa_meta_ff.pass ? 1'b0 : (sat || sa_meta_ff.aflag);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_w_ff, rsp_idx_ff};
   assign rsp_tuser  = rsp_flag_ff;

endmodule

/* rtl/fl1ag_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module fl1ag_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/fl1ag_rate.sv */
// Pipelined adaptive rate: floor(lr*2^16 / (1.0 + sqrt(G))), one root bit and one quotient bit a stage.
module fl1ag_rate (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  fl1ag_pkg::meta_type           in_meta,
   input  logic [fl1ag_pkg::ACC_W-1:0]   in_acc,
   input  logic [fl1ag_pkg::WORD_W-1:0]  lr,
   output logic                          out_valid,
   output fl1ag_pkg::meta_type           out_meta,
   output logic [fl1ag_pkg::WORD_W-1:0]  out_quot
);

   logic                       sq_valid_ff [fl1ag_pkg::SQRT_STAGES];
   fl1ag_pkg::meta_type        sq_meta_ff  [fl1ag_pkg::SQRT_STAGES];
   logic [63:0]                sq_v_ff     [fl1ag_pkg::SQRT_STAGES];
   logic [33:0]                sq_rem_ff   [fl1ag_pkg::SQRT_STAGES];
   logic [31:0]                sq_root_ff  [fl1ag_pkg::SQRT_STAGES];

   logic                       dv_valid_ff [fl1ag_pkg::DIV_STAGES];
   fl1ag_pkg::meta_type        dv_meta_ff  [fl1ag_pkg::DIV_STAGES];
   logic [33:0]                dv_rem_ff   [fl1ag_pkg::DIV_STAGES];
   logic [31:0]                dv_quot_ff  [fl1ag_pkg::DIV_STAGES];
   logic [32:0]                dv_den_ff   [fl1ag_pkg::DIV_STAGES];
   logic [31:0]                dv_num_ff   [fl1ag_pkg::DIV_STAGES];

   // square root of G*2^16, two radicand bits per stage
   for (genvar k = 0; k < fl1ag_pkg::SQRT_STAGES; k++) begin : g_sqrt
      logic                valid_src;
      fl1ag_pkg::meta_type meta_src;
      logic [63:0]         v_src;
      logic [33:0]         rem_src;
      logic [31:0]         root_src;
      logic [35:0]         rem_t;
      logic [35:0]         trial;
      logic                ge;

      if (k == 0) begin : g_first
         assign valid_src = in_valid;
         assign meta_src  = in_meta;
         assign v_src     = {in_acc, 16'd0};
         assign rem_src   = '0;
         assign root_src  = '0;
      end else begin : g_next
         assign valid_src = sq_valid_ff[k-1];
         assign meta_src  = sq_meta_ff[k-1];
         assign v_src     = sq_v_ff[k-1];
         assign rem_src   = sq_rem_ff[k-1];
         assign root_src  = sq_root_ff[k-1];
      end

      always_comb begin
         rem_t = {rem_src, v_src[63:62]};
         trial = {2'b00, root_src, 2'b01};
         ge    = (rem_t >= trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[k] <= 1'b0;
         end else if (adv) begin
            sq_valid_ff[k] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_meta_ff[k] <= meta_src;
            sq_v_ff[k]    <= {v_src[61:0], 2'b00};
            sq_rem_ff[k]  <= ge ? 34'(rem_t - trial) : rem_t[33:0];
            sq_root_ff[k] <= {root_src[30:0], ge};
         end
      end
   end

   // restoring division; quotient is known to fit in 32 bits since den >= 1.0
   for (genvar k = 0; k < fl1ag_pkg::DIV_STAGES; k++) begin : g_div
      logic                valid_src;
      fl1ag_pkg::meta_type meta_src;
      logic [33:0]         rem_src;
      logic [31:0]         quot_src;
      logic [32:0]         den_src;
      logic [31:0]         num_src;
      logic [33:0]         rem_t;
      logic                ge;

      if (k == 0) begin : g_first
         assign valid_src = sq_valid_ff[fl1ag_pkg::SQRT_STAGES-1];
         assign meta_src  = sq_meta_ff[fl1ag_pkg::SQRT_STAGES-1];
         assign rem_src   = {18'd0, lr[31:16]};
         assign quot_src  = '0;
         assign den_src   = {1'b0, sq_root_ff[fl1ag_pkg::SQRT_STAGES-1]} + 33'd65536;
         assign num_src   = {lr[15:0], 16'd0};
      end else begin : g_next
         assign valid_src = dv_valid_ff[k-1];
         assign meta_src  = dv_meta_ff[k-1];
         assign rem_src   = dv_rem_ff[k-1];
         assign quot_src  = dv_quot_ff[k-1];
         assign den_src   = dv_den_ff[k-1];
         assign num_src   = dv_num_ff[k-1];
      end

      always_comb begin
         rem_t = {rem_src[32:0], num_src[31]};
         ge    = (rem_t >= {1'b0, den_src});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k] <= 1'b0;
         end else if (adv) begin
            dv_valid_ff[k] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_meta_ff[k] <= meta_src;
            dv_rem_ff[k]  <= ge ? (rem_t - {1'b0, den_src}) : rem_t;
            dv_quot_ff[k] <= {quot_src[30:0], ge};
            dv_den_ff[k]  <= den_src;
            dv_num_ff[k]  <= {num_src[30:0], 1'b0};
         end
      end
   end

   assign out_valid = dv_valid_ff[fl1ag_pkg::DIV_STAGES-1];
   assign out_meta  = dv_meta_ff[fl1ag_pkg::DIV_STAGES-1];
   assign out_quot  = dv_quot_ff[fl1ag_pkg::DIV_STAGES-1];

endmodule

/* rtl/fl1ag_checker.sv */
// Port-level checks for the optimizer update core, bound to the top level.
module fl1ag_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [79:0]                     req_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [47:0]                     rsp_tdata,
   input logic                            rsp_tuser,
   input logic                            csr_valid,
   input logic                            csr_ready,
   input logic [fl1ag_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [31:0]                     csr_data
);

   // a held result must not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp changed while stalled");

   // store clearing starts right after reset, no input taken
   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_tready)
      else $error("input accepted during clearing pass");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // index zero passes through without a flag
   a_idx0_noflag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[15:0] == 16'd0) |-> !rsp_tuser)
      else $error("flag raised for index zero");

endmodule

bind fobos_l1_adagrad_update_core fl1ag_checker u_fl1ag_checker (.*);
